@@ hdl/asb_pkg.sv @@
// Shared types and constants for the additive sprite blitter.
package asb_pkg;

	localparam int FRAME_DIM_DEF  = 256;
	localparam int SPRITE_DIM_DEF = 100;
	localparam logic [7:0] SAT_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_DRAW,
		ST_RESP
	} state_t;

endpackage

@@ hdl/asb_in_if.sv @@
// Command channel of the blitter: one operation per word.
interface asb_in_if import asb_pkg::*;;
	logic       valid;
	logic       ready;
	op_t        func;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [6:0] sprite_col;
	logic [6:0] sprite_row;
	logic [7:0] sprite_value;

	modport source (output valid, func, pos_x, pos_y, sprite_col, sprite_row, sprite_value,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, sprite_col, sprite_row, sprite_value,
		output ready);
endinterface

@@ hdl/asb_out_if.sv @@
// Result channel of the blitter: one word per finished operation.
interface asb_out_if import asb_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] read_value;
	op_t        completed_op;

	modport source (output valid, read_value, completed_op, input ready);
	modport sink (input valid, read_value, completed_op, output ready);
endinterface

@@ hdl/additive_sprite_blitter_top.sv @@
// Saturating additive sprite blitter: frame store, sprite store and a draw sequencer.
//
// cmd carries one operation per word (load sprite entry, clear frame, draw
// sprite, read pixel); rsp returns one word per operation with the pixel value
// for a read (zero otherwise) and the echoed operation code.
// Work is one operation at a time; cmd.ready is high only when idle.
// Load and read act on their store when the command is accepted; clear zeroes
// one frame entry per cycle, and draw does one frame read-modify-write per
// sprite pixel through a single read port and a single write port, the
// write of one pixel overlapping the read of the next; a sprite row that runs
// past the right frame edge ends at the first column outside the frame, and
// rows below the frame are not visited.
// After reset the frame store is zeroed by a sweep, during which cmd.ready
// stays low. The sprite store is not cleared.
// The result sits in an output register; when rsp stalls, the next command is
// still accepted and runs, holding its own result until the register frees.
module additive_sprite_blitter_top import asb_pkg::*; #(
	parameter int FRAME_DIM  = FRAME_DIM_DEF,
	parameter int SPRITE_DIM = SPRITE_DIM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	asb_in_if.sink    cmd,
	asb_out_if.source rsp
);

	localparam int FDEPTH = FRAME_DIM * FRAME_DIM;
	localparam int FAW    = $clog2(FDEPTH);
	localparam int SDEPTH = SPRITE_DIM * SPRITE_DIM;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int SW     = (SPRITE_DIM > 1) ? $clog2(SPRITE_DIM) : 1;
	localparam int CW     = $clog2(FRAME_DIM + 512);

	logic [7:0] frame_mem [FDEPTH];
	logic [7:0] sprite_mem [SDEPTH];

	state_t state_q, state_d;

	logic [FAW-1:0] clr_cnt_q;
	logic [SW-1:0]  walk_col_q, walk_row_q;
	logic [7:0]     ox_q, oy_q;
	logic [FAW-1:0] row_base_q;
	logic [SAW-1:0] spr_base_q;
	op_t            op_q;
	logic           hit_q;

	logic           draw_v_s1;
	logic [FAW-1:0] f_addr_s1;

	logic [7:0] f_rdata_q, s_rdata_q;

	logic       out_valid_q;
	logic [7:0] read_value_q;
	op_t        completed_op_q;

	logic           accept;
	logic [CW-1:0]  fx, fy;
	logic           row_ok, col_ok, col_last, row_last;
	logic           issue, row_adv, walk_clr, clr_adv, out_load;
	logic           f_re, f_we, s_we;
	logic [FAW-1:0] f_raddr, f_waddr, rd_addr, draw_addr;
	logic [7:0]     f_wdata;
	logic [SAW-1:0] s_raddr, load_addr;
	logic           load_ok, read_ok;
	logic [8:0]     sum;
	logic [7:0]     sat;

	assign accept    = cmd.valid && cmd.ready;
	assign fx        = CW'(ox_q) + CW'(walk_col_q);
	assign fy        = CW'(oy_q) + CW'(walk_row_q);
	assign row_ok    = fy < CW'(FRAME_DIM);
	assign col_ok    = fx < CW'(FRAME_DIM);
	assign col_last  = walk_col_q == SW'(SPRITE_DIM - 1);
	assign row_last  = walk_row_q == SW'(SPRITE_DIM - 1);
	assign draw_addr = row_base_q + FAW'(fx);
	assign s_raddr   = spr_base_q + SAW'(walk_col_q);

	assign load_ok   = ({2'b00, cmd.sprite_col} < 9'(SPRITE_DIM))
		&& ({2'b00, cmd.sprite_row} < 9'(SPRITE_DIM));
	assign load_addr = SAW'(16'(cmd.sprite_row) * 16'(SPRITE_DIM) + 16'(cmd.sprite_col));
	assign read_ok   = (CW'(cmd.pos_x) < CW'(FRAME_DIM)) && (CW'(cmd.pos_y) < CW'(FRAME_DIM));
	assign rd_addr   = FAW'(FAW'(cmd.pos_y) * FAW'(FRAME_DIM) + FAW'(cmd.pos_x));

	assign sum = {1'b0, f_rdata_q} + {1'b0, s_rdata_q};
	assign sat = sum[8] ? SAT_MAX : sum[7:0];

	assign cmd.ready = state_q == ST_IDLE;
	assign out_load  = !out_valid_q || rsp.ready;

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		row_adv  = 1'b0;
		walk_clr = 1'b0;
		clr_adv  = 1'b0;
		s_we     = 1'b0;
		f_re     = 1'b0;
		f_raddr  = draw_addr;
		unique case (state_q)
			ST_INIT: begin
				clr_adv = 1'b1;
				if (clr_cnt_q == FAW'(FDEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.func)
						OP_LOAD: begin
							s_we    = load_ok;
							state_d = ST_RESP;
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_DRAW:  state_d = ST_DRAW;
						OP_READ: begin
							f_re    = read_ok;
							f_raddr = rd_addr;
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				clr_adv = 1'b1;
				if (clr_cnt_q == FAW'(FDEPTH - 1)) state_d = ST_RESP;
			end
			ST_DRAW: begin
				if (!row_ok) begin
					walk_clr = 1'b1;
					state_d  = ST_RESP;
				end else begin
					issue   = col_ok;
					f_re    = col_ok;
					row_adv = !col_ok || col_last;
					if (row_adv && row_last) begin
						walk_clr = 1'b1;
						state_d  = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
		endcase
	end

	// frame write port: zero sweep or the write half of a draw pixel
	always_comb begin
		f_we    = 1'b0;
		f_waddr = f_addr_s1;
		f_wdata = sat;
		if (clr_adv) begin
			f_we    = 1'b1;
			f_waddr = clr_cnt_q;
			f_wdata = 8'd0;
		end else if (draw_v_s1) begin
			f_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) frame_mem[f_waddr] <= f_wdata;
		if (f_re) f_rdata_q <= frame_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) sprite_mem[load_addr] <= cmd.sprite_value;
		if (issue) s_rdata_q <= sprite_mem[s_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_cnt_q   <= '0;
			walk_col_q  <= '0;
			walk_row_q  <= '0;
			draw_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			draw_v_s1 <= issue;
			if (clr_adv) begin
				if (clr_cnt_q == FAW'(FDEPTH - 1)) clr_cnt_q <= '0;
				else clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (walk_clr) begin
				walk_col_q <= '0;
				walk_row_q <= '0;
			end else if (row_adv) begin
				walk_col_q <= '0;
				walk_row_q <= walk_row_q + 1'b1;
			end else if (issue) begin
				walk_col_q <= walk_col_q + 1'b1;
			end
			if (state_q == ST_RESP && out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		f_addr_s1 <= draw_addr;
		if (accept) begin
			op_q       <= cmd.func;
			hit_q      <= (cmd.func == OP_READ) && read_ok;
			ox_q       <= cmd.pos_x;
			oy_q       <= cmd.pos_y;
			row_base_q <= FAW'(FAW'(cmd.pos_y) * FAW'(FRAME_DIM));
			spr_base_q <= '0;
		end else if (row_adv) begin
			row_base_q <= row_base_q + FAW'(FRAME_DIM);
			spr_base_q <= spr_base_q + SAW'(SPRITE_DIM);
		end
		if (state_q == ST_RESP && out_load) begin
			read_value_q   <= hit_q ? f_rdata_q : 8'd0;
			completed_op_q <= op_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_value   = read_value_q;
	assign rsp.completed_op = completed_op_q;

endmodule
